[hw/rtl/changed_word_run_diff_encoder_macros.svh]
// Assertion macros shared by the encoder RTL.
`ifndef CHANGED_WORD_RUN_DIFF_ENCODER_MACROS_SVH
`define CHANGED_WORD_RUN_DIFF_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CWRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CWRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cwrd_pkg.sv]
`default_nettype none

package cwrd_pkg;

  // One result beat, before packing onto the output stream.
  typedef struct packed {
    logic        write_valid;
    logic [31:0] write_position;
    logic [63:0] write_data;
    logic [31:0] diff_length;
    logic        run_done;
  } result_t;

  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;

  // Register index, taken from the word address paddr[2].
  localparam logic [0:0] REG_GAP_WINDOW = 1'b0;

  localparam logic [7:0] GAP_WINDOW_RESET = 8'd12;

  localparam int unsigned EQ_COUNT_BITS = 9;
  localparam int unsigned IN_TDATA_BITS = 160;
  localparam int unsigned OUT_TDATA_BITS = 136;

endpackage

`default_nettype wire

[hw/rtl/cwrd_step.sv]
`default_nettype none

// Per-word run decision: takes the run state and one word, and produces
// one or two result beats together with the state after the word.
module cwrd_step #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  wire logic [INDEX_BITS-1:0]              word_index,
  input  wire logic [63:0]                        new_word,
  input  wire logic [63:0]                        old_word,
  input  wire logic                               interval_last,
  input  wire logic                               frame_first,
  input  wire logic [7:0]                         gap_window,
  input  wire logic                               run_open,
  input  wire logic [31:0]                        header_slot,
  input  wire logic [INDEX_BITS-1:0]              run_start_index,
  input  wire logic [cwrd_pkg::EQ_COUNT_BITS-1:0] equal_count,
  input  wire logic [31:0]                        write_pointer,
  output cwrd_pkg::result_t                       res0,
  output cwrd_pkg::result_t                       res1,
  output logic                                    two_results,
  output logic                                    run_open_next,
  output logic [31:0]                             header_slot_next,
  output logic [INDEX_BITS-1:0]                   run_start_index_next,
  output logic [cwrd_pkg::EQ_COUNT_BITS-1:0]      equal_count_next,
  output logic [31:0]                             write_pointer_next
);

  logic                               eq;
  logic                               open0;
  logic [31:0]                        wp0;
  logic [31:0]                        hs0;
  logic [cwrd_pkg::EQ_COUNT_BITS-1:0] ec0;
  logic [31:0]                        wp1;
  logic [31:0]                        hs1;
  logic [INDEX_BITS-1:0]              start1;
  logic [cwrd_pkg::EQ_COUNT_BITS-1:0] ec1;
  logic [31:0]                        wp2;
  logic [cwrd_pkg::EQ_COUNT_BITS-1:0] ec2;
  logic                               close;
  logic [INDEX_BITS-1:0]              end_index;
  logic [31:0]                        wp3;

  always_comb begin
    eq = (new_word == old_word);

    // A new frame drops any open run and restarts positions at zero.
    open0 = run_open & ~frame_first;
    wp0   = frame_first ? 32'd0 : write_pointer;
    hs0   = frame_first ? 32'd0 : header_slot;
    ec0   = frame_first ? '0 : equal_count;

    // Opening a run reserves the header slot at the current pointer.
    if (!open0) begin
      hs1    = wp0;
      start1 = word_index;
      wp1    = wp0 + 32'd1;
      ec1    = '0;
    end else begin
      hs1    = hs0;
      start1 = run_start_index;
      wp1    = wp0;
      ec1    = ec0;
    end

    wp2   = wp1 + 32'd1;
    ec2   = eq ? ec1 + cwrd_pkg::EQ_COUNT_BITS'(1) : '0;
    close = (ec2 > {1'b0, gap_window}) | interval_last;

    end_index = word_index + INDEX_BITS'(1) - INDEX_BITS'(ec2);
    wp3       = wp2 - 32'(ec2);

    res0 = '0;
    res1 = '0;
    two_results = 1'b0;

    if (!open0 && eq) begin
      // Equal word outside a run: a single no-write beat.
      res0.diff_length = wp0;
      res0.run_done    = 1'b1;
      run_open_next        = 1'b0;
      header_slot_next     = hs0;
      run_start_index_next = run_start_index;
      equal_count_next     = '0;
      write_pointer_next   = wp0;
    end else begin
      res0.write_valid    = 1'b1;
      res0.write_position = wp1;
      res0.write_data     = new_word;
      res0.diff_length    = hs1;
      res0.run_done       = ~close;
      header_slot_next     = hs1;
      run_start_index_next = start1;
      if (close) begin
        // Trailing equal words are dropped, then the header is written.
        two_results         = 1'b1;
        res1.write_valid    = 1'b1;
        res1.write_position = hs1;
        res1.write_data     = {32'(end_index), 32'(start1)};
        res1.diff_length    = wp3;
        res1.run_done       = 1'b1;
        run_open_next       = 1'b0;
        equal_count_next    = '0;
        write_pointer_next  = wp3;
      end else begin
        run_open_next      = 1'b1;
        equal_count_next   = ec2;
        write_pointer_next = wp2;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/changed_word_run_diff_encoder.sv]
// Channel   Direction  tdata (low bit up)                            Side bits
// s_axis    in         word_index, new_word, old_word                tlast=interval_last,
//                                                                  tuser=frame_first
// m_axis    out        write_valid, write_position, write_data,      tlast=run_done
//                      diff_length, zero pad to 136 bits
// apb       in/out     gap_window at byte address 0                  pready tied high
//
// A word is decided in the cycle it is accepted; its beats appear on m_axis from the
// next cycle on. One word per cycle is taken while each word yields one beat and
// m_tready is high; a word that closes a run yields two beats, and the next word
// waits until the first has left. The output stage holds up to two beats; s_tready
// follows it and m_tready. Reset (rst, synchronous) closes any run, zeroes the
// positions and sets gap_window to 12. No clearing pass is needed.
`default_nettype none

`include "changed_word_run_diff_encoder_macros.svh"

module changed_word_run_diff_encoder #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // word_index[31:0], new_word[95:32], old_word[159:96]
  input  wire logic [cwrd_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic                                 s_tlast,
  // frame_first[0]
  input  wire logic                                 s_tuser,
  // write_valid[0], write_position[32:1], write_data[96:33], diff_length[128:97]
  output logic [cwrd_pkg::OUT_TDATA_BITS-1:0]       m_tdata,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic                                      m_tlast,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [cwrd_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  wire logic [cwrd_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [cwrd_pkg::CFG_DATA_BITS-1:0]        prdata,
  output logic                                      pready
);

  // Configuration register.
  logic [7:0] gap_window;
  logic [0:0] reg_index;

  // Run state.
  logic                               run_open;
  logic [31:0]                        header_slot;
  logic [INDEX_BITS-1:0]              run_start_index;
  logic [cwrd_pkg::EQ_COUNT_BITS-1:0] equal_count;
  logic [31:0]                        write_pointer;

  logic                               run_open_next;
  logic [31:0]                        header_slot_next;
  logic [INDEX_BITS-1:0]              run_start_index_next;
  logic [cwrd_pkg::EQ_COUNT_BITS-1:0] equal_count_next;
  logic [31:0]                        write_pointer_next;

  cwrd_pkg::result_t res0;
  cwrd_pkg::result_t res1;
  logic              two_results;

  // Output stage: slot0 is the beat on the bus, slot1 the one queued behind it.
  cwrd_pkg::result_t slot0;
  cwrd_pkg::result_t slot1;
  logic [1:0]        count;

  logic push;
  logic pop;

  assign pready    = 1'b1;
  assign reg_index = paddr[2:2];

  // gap_window is written on the access phase of an APB write to its address.
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_window <= cwrd_pkg::GAP_WINDOW_RESET;
    end else if (psel && penable && pwrite && pready
                 && reg_index == cwrd_pkg::REG_GAP_WINDOW) begin
      gap_window <= pwdata[7:0];
    end
  end

  always_comb begin
    if (reg_index == cwrd_pkg::REG_GAP_WINDOW) begin
      prdata = cwrd_pkg::CFG_DATA_BITS'(gap_window);
    end else begin
      prdata = '0;
    end
  end

  // The whole decision for one word happens here, between the run state and
  // the output stage.
  cwrd_step #(
    .INDEX_BITS(INDEX_BITS)
  ) u_step (
    .word_index           (s_tdata[INDEX_BITS-1:0]),
    .new_word             (s_tdata[95:32]),
    .old_word             (s_tdata[159:96]),
    .interval_last        (s_tlast),
    .frame_first          (s_tuser),
    .gap_window           (gap_window),
    .run_open             (run_open),
    .header_slot          (header_slot),
    .run_start_index      (run_start_index),
    .equal_count          (equal_count),
    .write_pointer        (write_pointer),
    .res0                 (res0),
    .res1                 (res1),
    .two_results          (two_results),
    .run_open_next        (run_open_next),
    .header_slot_next     (header_slot_next),
    .run_start_index_next (run_start_index_next),
    .equal_count_next     (equal_count_next),
    .write_pointer_next   (write_pointer_next)
  );

  // A new word is taken when the output stage will be empty after this
  // cycle's beat leaves, so that both of its beats always fit.
  assign s_tready = (count == 2'd0) || (count == 2'd1 && m_tready);
  assign push     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open        <= 1'b0;
      header_slot     <= '0;
      run_start_index <= '0;
      equal_count     <= '0;
      write_pointer   <= '0;
    end else if (push) begin
      run_open        <= run_open_next;
      header_slot     <= header_slot_next;
      run_start_index <= run_start_index_next;
      equal_count     <= equal_count_next;
      write_pointer   <= write_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push) begin
      count <= two_results ? 2'd2 : 2'd1;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign m_tvalid = (count != 2'd0);
  assign m_tlast  = slot0.run_done;
  assign m_tdata  = {7'd0, slot0.diff_length, slot0.write_data,
                     slot0.write_position, slot0.write_valid};

  `CWRD_ASSERT_NOW(a_count_bound, 1'b1, count != 2'd3, "output stage over two beats")
  `CWRD_ASSERT_NOW(a_closed_no_count, !run_open, equal_count == '0, "count kept after close")
  `CWRD_ASSERT_NEXT(a_two_beats, push && two_results,
                    count == 2'd2 && !m_tlast, "closing word lost a beat")
  `CWRD_ASSERT_NEXT(a_drain, pop && count == 2'd1 && !push, !m_tvalid,
                    "beat repeated after drain")

endmodule

`default_nettype wire

[tb/tb_changed_word_run_diff_encoder.sv]
`timescale 1ns / 100ps

module tb_changed_word_run_diff_encoder;

  // One word of a damaged interval, as it travels on the input stream.
  typedef struct packed {
    logic [31:0] word_index;
    logic [63:0] new_word;
    logic [63:0] old_word;
    logic        interval_last;
    logic        frame_first;
  } word_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Input stream. s_tdata: word_index, new_word, old_word (low bit up).
  logic [cwrd_pkg::IN_TDATA_BITS-1:0]  s_tdata = '0;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  logic                                s_tlast = 1'b0;
  logic                                s_tuser = 1'b0;   // frame_first
  // Output stream. m_tdata: write_valid, write_position, write_data, diff_length, pad.
  logic [cwrd_pkg::OUT_TDATA_BITS-1:0] m_tdata;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic                                m_tlast;          // run_done
  // Register port.
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [cwrd_pkg::CFG_ADDR_BITS-1:0]  paddr = '0;
  logic [cwrd_pkg::CFG_DATA_BITS-1:0]  pwdata = '0;
  logic [cwrd_pkg::CFG_DATA_BITS-1:0]  prdata;
  logic                                pready;

  changed_word_run_diff_encoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The run is cut off here if the block ever hangs.
  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

  // Words waiting to be offered, and the diff writes that accepted words must cause.
  word_beat_t         pending_words[$];
  cwrd_pkg::result_t  expected_writes[$];
  word_beat_t         offered_word;
  cwrd_pkg::result_t  head_write;
  int unsigned        words_planned = 0;
  int unsigned        words_accepted = 0;
  int unsigned        beats_checked = 0;
  int unsigned        mismatch_count = 0;
  bit                 idle_enable = 1'b1;
  int unsigned        hold_left = 0;
  bit                 hold_done = 1'b0;

  // Shadow of the encoder: the register and the run state, at their reset values.
  logic [7:0]         enc_gap_window = cwrd_pkg::GAP_WINDOW_RESET;
  logic               enc_run_open = 1'b0;
  logic [31:0]        enc_header_slot = '0;
  logic [31:0]        enc_start_index = '0;
  logic [cwrd_pkg::EQ_COUNT_BITS-1:0] enc_equal_count = '0;
  logic [31:0]        enc_write_ptr = '0;

  // Works out the diff writes caused by one accepted word and queues them in order.
  // Every word yields one beat; a word that closes a run adds the header beat.
  function automatic void encode_word(input word_beat_t w);
    logic              same;
    logic [31:0]       end_index;
    cwrd_pkg::result_t wr;
    same = (w.new_word == w.old_word);
    if (w.frame_first) begin
      // A new frame abandons any open run without a header.
      enc_write_ptr   = '0;
      enc_header_slot = '0;
      enc_run_open    = 1'b0;
      enc_equal_count = '0;
    end
    if (!enc_run_open) begin
      if (same) begin
        // Nothing changed and no run open: a beat that writes nothing.
        wr.write_valid    = 1'b0;
        wr.write_position = '0;
        wr.write_data     = '0;
        wr.diff_length    = enc_write_ptr;
        wr.run_done       = 1'b1;
        expected_writes.push_back(wr);
        return;
      end
      // Open a run and reserve the slot for its header.
      enc_header_slot = enc_write_ptr;
      enc_start_index = w.word_index;
      enc_write_ptr   = enc_write_ptr + 32'd1;
      enc_equal_count = '0;
      enc_run_open    = 1'b1;
    end
    // Inside a run every word is written, changed or not.
    wr.write_valid    = 1'b1;
    wr.write_position = enc_write_ptr;
    wr.write_data     = w.new_word;
    wr.diff_length    = enc_header_slot;
    wr.run_done       = 1'b0;
    enc_write_ptr     = enc_write_ptr + 32'd1;
    enc_equal_count   = same ? enc_equal_count + cwrd_pkg::EQ_COUNT_BITS'(1) : '0;
    if (enc_equal_count > {1'b0, enc_gap_window} || w.interval_last) begin
      expected_writes.push_back(wr);
      // Trailing equal words are dropped, then the header fills the reserved slot.
      end_index         = w.word_index + 32'd1 - 32'(enc_equal_count);
      enc_write_ptr     = enc_write_ptr - 32'(enc_equal_count);
      wr.write_valid    = 1'b1;
      wr.write_position = enc_header_slot;
      wr.write_data     = {end_index, enc_start_index};
      wr.diff_length    = enc_write_ptr;
      enc_run_open      = 1'b0;
      enc_equal_count   = '0;
    end
    wr.run_done = 1'b1;
    expected_writes.push_back(wr);
  endfunction

  // Driver: offers the next pending word, holding each one until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        encode_word(offered_word);
        words_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 && !(idle_enable && $urandom_range(0, 99) < 23)) begin
          offered_word = pending_words.pop_front();
          s_tdata  <= {offered_word.old_word, offered_word.new_word, offered_word.word_index};
          s_tlast  <= offered_word.interval_last;
          s_tuser  <= offered_word.frame_first;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once a few hundred beats have
  // passed, so that the output stage fills and the input side backs up.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!hold_done && beats_checked >= 300) begin
      hold_left <= 300;
      hold_done <= 1'b1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= !(idle_enable && $urandom_range(0, 99) < 23);
    end
  end

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: every diff write beat is held against the oldest expected write.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_checked <= beats_checked + 1;
      if (expected_writes.size() == 0) begin
        $error("diff write beat arrived with no write expected");
        mismatch_count++;
      end else begin
        head_write = expected_writes.pop_front();
        check_field("write_valid", 64'(head_write.write_valid), 64'(m_tdata[0]));
        check_field("write_position", 64'(head_write.write_position), 64'(m_tdata[32:1]));
        check_field("write_data", head_write.write_data, m_tdata[96:33]);
        check_field("diff_length", 64'(head_write.diff_length), 64'(m_tdata[128:97]));
        check_field("run_done", 64'(head_write.run_done), 64'(m_tlast));
      end
    end
  end

  // A register write: setup cycle, then access until pready is seen.
  task automatic write_gap_window(input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {cwrd_pkg::REG_GAP_WINDOW, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    enc_gap_window = value;
  endtask

  task automatic plan_word(input logic [31:0] index, input logic [63:0] new_w,
                           input logic [63:0] old_w, input logic last, input logic first);
    word_beat_t w;
    w.word_index    = index;
    w.new_word      = new_w;
    w.old_word      = old_w;
    w.interval_last = last;
    w.frame_first   = first;
    pending_words.push_back(w);
    words_planned++;
  endtask

  // Lengths of equal stretches cluster around the bridging limit, on both sides of it.
  function automatic int unsigned equal_run_length();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2);
      1: return 32'(enc_gap_window);
      2: return 32'(enc_gap_window) + 1;
      default: return $urandom_range(0, 32'(enc_gap_window) + 2);
    endcase
  endfunction

  // One damaged interval: alternating stretches of changed and equal words. A noisy
  // interval decides each word at random, and now and then the index jumps.
  task automatic plan_interval(input int unsigned n_words, input bit noisy);
    logic [31:0] index;
    logic [63:0] old_w;
    logic [63:0] flip;
    int unsigned seg;
    int unsigned i;
    bit          changed;
    bit          same;
    bit          new_frame;
    index     = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 24) : $urandom();
    changed   = ($urandom_range(0, 3) == 0);
    new_frame = ($urandom_range(0, 4) == 0);
    seg       = 0;
    for (i = 0; i < n_words; i++) begin
      while (seg == 0) begin
        changed = !changed;
        seg     = changed ? $urandom_range(1, 6) : equal_run_length();
      end
      same = noisy ? ($urandom_range(0, 1) == 1) : !changed;
      case ($urandom_range(0, 7))
        0: old_w = '0;
        1: old_w = '1;
        default: old_w = {$urandom(), $urandom()};
      endcase
      flip = ($urandom_range(0, 3) == 0) ? 64'd1 << $urandom_range(0, 63)
                                         : {$urandom(), $urandom()};
      if (flip == '0) flip = 64'd1;
      plan_word(index, same ? old_w : old_w ^ flip, old_w, i == n_words - 1,
                (i == 0 && new_frame) || $urandom_range(0, 59) == 0);
      seg--;
      index = ($urandom_range(0, 29) == 0) ? $urandom() : index + 32'd1;
    end
  endtask

  // Mostly short intervals, with some long enough to reach past the bridging limit.
  task automatic plan_random(input int unsigned budget);
    int unsigned target;
    target = words_planned + budget;
    while (words_planned < target) begin
      plan_interval(($urandom_range(0, 3) == 0)
                      ? $urandom_range(1, 2 * 32'(enc_gap_window) + 20)
                      : $urandom_range(1, 30),
                    $urandom_range(0, 9) == 0);
    end
  endtask

  // Waits until every planned word is taken and every expected write has arrived.
  task automatic drain();
    while (words_accepted != words_planned || expected_writes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset gap window.
    // An equal word with no run open writes nothing.
    plan_word(32'd0, 64'd0, 64'd0, 1'b0, 1'b1);
    // A run opened at the interval's last word, at the top index: the end wraps to zero.
    plan_word(32'hFFFF_FFFF, '1, '0, 1'b1, 1'b0);
    // A frame start while a run is open abandons it; the run then closes with a
    // trailing equal word dropped.
    plan_word(32'd100, 64'd1, 64'd0, 1'b0, 1'b0);
    plan_word(32'd101, 64'd5, 64'd5, 1'b0, 1'b0);
    plan_word(32'd102, 64'd0, 64'h8000_0000_0000_0000, 1'b0, 1'b1);
    plan_word(32'd103, 64'd7, 64'd7, 1'b1, 1'b0);
    // Indices that jump around inside one run.
    plan_word(32'd200, 64'd3, 64'd4, 1'b0, 1'b0);
    plan_word(32'd7, 64'd9, 64'd9, 1'b0, 1'b0);
    plan_word(32'd9, 64'd1, 64'd2, 1'b0, 1'b0);
    plan_word(32'd3, 64'd6, 64'd6, 1'b1, 1'b0);
    // A run that crosses the index wrap.
    plan_word(32'hFFFF_FFFE, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b0);
    plan_word(32'hFFFF_FFFF, 64'd0, 64'd1, 1'b0, 1'b0);
    plan_word(32'd0, '1, '1, 1'b1, 1'b0);
    // A new frame whose first word opens and closes a run, then an equal last word.
    plan_word(32'd50, '0, '1, 1'b1, 1'b1);
    plan_word(32'd51, '1, '1, 1'b1, 1'b0);
    plan_random(400);
    drain();

    // With no bridging at all, a single equal word closes the run.
    write_gap_window(8'd0);
    plan_word(32'd1, 64'd1, 64'd0, 1'b0, 1'b1);
    plan_word(32'd2, 64'd2, 64'd2, 1'b0, 1'b0);
    plan_word(32'd3, 64'd3, 64'd0, 1'b0, 1'b0);
    plan_word(32'd4, 64'd4, 64'd0, 1'b1, 1'b0);
    plan_random(300);
    drain();

    // Widest bridging; the equal counter must reach past eight bits to close.
    write_gap_window(8'd255);
    plan_random(300);
    drain();

    // A stretch with both sides running flat out.
    idle_enable = 1'b0;
    write_gap_window(8'd1);
    plan_random(300);
    drain();
    idle_enable = 1'b1;

    write_gap_window(8'd5);
    plan_random(230);
    drain();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_writes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/cwrd_pkg.sv
hw/rtl/cwrd_step.sv
hw/rtl/changed_word_run_diff_encoder.sv
tb/tb_changed_word_run_diff_encoder.sv
